// ===== hdl/ktxhp_pkg.sv =====
// shared types, constants and helpers of the ktx 1.1 header parser
// no dependencies; used by every module of the parser
package ktxhp_pkg;

  localparam int unsigned POS_W   = 34;
  localparam int unsigned PEND_W  = 35;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QIDX_W  = 2;
  localparam int unsigned QCNT_W  = 3;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [PEND_W-1:0] pend_t;

  localparam pos_t POS_MAX = {POS_W{1'b1}};
  localparam pos_t HDR_LEN = 34'd64;
  localparam pos_t MIN_LEN = 34'd68;
  localparam pos_t IDENT_LEN = 34'd12;

  localparam logic [31:0] ENDIAN_MARK  = 32'h0403_0201;
  localparam logic [31:0] GL_UBYTE     = 32'h0000_1401;
  localparam logic [31:0] GL_US565     = 32'h0000_8363;
  localparam logic [31:0] GL_RGB       = 32'h0000_1907;
  localparam logic [31:0] GL_RGBA      = 32'h0000_1908;
  localparam logic [31:0] IFMT_RGBA8   = 32'h0000_8058;
  localparam logic [31:0] IFMT_RGB565  = 32'h0000_8d62;
  localparam logic [31:0] GL_ETC1      = 32'h0000_8d64;

  // header word indexes (byte offset / 4)
  localparam logic [3:0] HW_ENDIAN  = 4'd3;
  localparam logic [3:0] HW_TYPE    = 4'd4;
  localparam logic [3:0] HW_FORMAT  = 4'd6;
  localparam logic [3:0] HW_IFORMAT = 4'd7;
  localparam logic [3:0] HW_WIDTH   = 4'd9;
  localparam logic [3:0] HW_HEIGHT  = 4'd10;
  localparam logic [3:0] HW_DEPTH   = 4'd11;
  localparam logic [3:0] HW_ARRAY   = 4'd12;
  localparam logic [3:0] HW_FACES   = 4'd13;
  localparam logic [3:0] HW_MIPS    = 4'd14;
  localparam logic [3:0] HW_KVLEN   = 4'd15;

  typedef enum logic [1:0] {
    FMT_ETC1     = 2'd0,
    FMT_RGB565   = 2'd1,
    FMT_RGBA8888 = 2'd2,
    FMT_NONE     = 2'd3
  } fmt_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_BAD_HEADER = 4'd1,
    ST_ENDIAN     = 4'd2,
    ST_FORMAT     = 4'd3,
    ST_SHAPE      = 4'd4,
    ST_SIZE_WORD  = 4'd5,
    ST_PAYLOAD    = 4'd6,
    ST_DIMS       = 4'd7,
    ST_MISMATCH   = 4'd8
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  pb;
    status_t     st;
    fmt_t        pf;
    logic [31:0] w;
    logic [31:0] h;
    logic        last;
  } result_t;

  // up to two results pushed per accepted word, e0 first
  typedef struct packed {
    logic [1:0] n;
    result_t    e0;
    result_t    e1;
  } push_t;

  function automatic logic [7:0] ident_byte(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'hab;
      4'd1:    v = 8'h4b;
      4'd2:    v = 8'h54;
      4'd3:    v = 8'h58;
      4'd4:    v = 8'h20;
      4'd5:    v = 8'h31;
      4'd6:    v = 8'h31;
      4'd7:    v = 8'hbb;
      4'd8:    v = 8'h0d;
      4'd9:    v = 8'h0a;
      4'd10:   v = 8'h1a;
      4'd11:   v = 8'h0a;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic fmt_t decode_fmt(input logic [31:0] t0, input logic [31:0] t1,
                                      input logic [31:0] t2);
    fmt_t f;
    if (t0 == 32'd0 && t1 == 32'd0 && t2 == GL_ETC1)
      f = FMT_ETC1;
    else if (t0 == GL_US565 && t1 == GL_RGB && t2 == IFMT_RGB565)
      f = FMT_RGB565;
    else if (t0 == GL_UBYTE && t1 == GL_RGBA && t2 == IFMT_RGBA8)
      f = FMT_RGBA8888;
    else
      f = FMT_NONE;
    return f;
  endfunction

  function automatic logic dims_ok(input logic [31:0] w, input logic [31:0] h);
    return (w != 32'd0) && !w[31] && (h != 32'd0) && !h[31];
  endfunction

endpackage

// ===== hdl/ktxhp_size.sv =====
// expected payload size: one multiply stage, then one scaling stage
// depends on ktxhp_pkg
module ktxhp_size (
  input  logic             clk,
  input  logic [31:0]      width,
  input  logic [31:0]      height,
  input  ktxhp_pkg::fmt_t  fmt,
  output logic [63:0]      exp_size
);

  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [32:0] w_rnd;
  logic [32:0] h_rnd;
  logic [1:0]  sh_nxt;
  logic [1:0]  sh_r;
  logic [63:0] prod_r;
  logic [63:0] exp_r;

  assign w_rnd = {1'b0, width} + 33'd3;
  assign h_rnd = {1'b0, height} + 33'd3;

  always_comb begin
    op_a   = width;
    op_b   = height;
    sh_nxt = 2'd0;
    case (fmt)
      ktxhp_pkg::FMT_ETC1: begin
        // 4x4 blocks of 8 bytes
        op_a   = {1'b0, w_rnd[32:2]};
        op_b   = {1'b0, h_rnd[32:2]};
        sh_nxt = 2'd3;
      end
      ktxhp_pkg::FMT_RGB565:   sh_nxt = 2'd1;
      ktxhp_pkg::FMT_RGBA8888: sh_nxt = 2'd2;
      default:                 sh_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    sh_r   <= sh_nxt;
    exp_r  <= prod_r << sh_r;
  end

  assign exp_size = exp_r;

endmodule

// ===== hdl/ktxhp_parse.sv =====
// byte-serial header walker: identifier, header words, size word, payload window, status
// depends on ktxhp_pkg; takes the expected size from ktxhp_size
module ktxhp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic [7:0]           file_byte,
  input  logic                 end_of_file,
  input  logic [63:0]          exp_size,
  output logic [31:0]          width,
  output logic [31:0]          height,
  output ktxhp_pkg::fmt_t      fmt,
  output ktxhp_pkg::push_t     push
);

  ktxhp_pkg::pos_t    p_r, p_nxt, p_inc, len;
  logic [31:0]        ws_r, ws_nxt, ws_sh;
  ktxhp_pkg::status_t fe_r, fe_nxt, st;
  logic [31:0]        t0_r, t0_nxt, t1_r, t1_nxt;
  ktxhp_pkg::fmt_t    fmt_r, fmt_nxt;
  logic [31:0]        w_r, w_nxt, h_r, h_nxt;
  ktxhp_pkg::pos_t    ps_r, ps_nxt, ps4_r, ps4_nxt;
  logic [31:0]        isw_r, isw_nxt;
  ktxhp_pkg::pend_t   pend_r, pend_nxt;
  ktxhp_pkg::result_t pay, sts;
  logic               live, pay_v;

  assign live  = (p_r != ktxhp_pkg::POS_MAX);
  assign p_inc = p_r + 34'd1;
  assign ws_sh = {file_byte, ws_r[31:8]};

  always_comb begin
    p_nxt    = p_r;
    ws_nxt   = ws_r;
    fe_nxt   = fe_r;
    t0_nxt   = t0_r;
    t1_nxt   = t1_r;
    fmt_nxt  = fmt_r;
    w_nxt    = w_r;
    h_nxt    = h_r;
    ps_nxt   = ps_r;
    ps4_nxt  = ps4_r;
    isw_nxt  = isw_r;
    pend_nxt = pend_r;
    pay_v    = 1'b0;
    st       = ktxhp_pkg::ST_OK;

    if (live) begin
      if (p_r < ktxhp_pkg::IDENT_LEN && file_byte != ktxhp_pkg::ident_byte(p_r[3:0]) &&
          fe_nxt == ktxhp_pkg::ST_OK)
        fe_nxt = ktxhp_pkg::ST_BAD_HEADER;
      if (p_r < ktxhp_pkg::HDR_LEN) begin
        ws_nxt = ws_sh;
        if (p_r[1:0] == 2'd3) begin
          case (p_r[5:2])
            ktxhp_pkg::HW_ENDIAN:
              if (ws_sh != ktxhp_pkg::ENDIAN_MARK && fe_nxt == ktxhp_pkg::ST_OK)
                fe_nxt = ktxhp_pkg::ST_ENDIAN;
            ktxhp_pkg::HW_TYPE:    t0_nxt = ws_sh;
            ktxhp_pkg::HW_FORMAT:  t1_nxt = ws_sh;
            ktxhp_pkg::HW_IFORMAT: begin
              fmt_nxt = ktxhp_pkg::decode_fmt(t0_r, t1_r, ws_sh);
              if (fmt_nxt == ktxhp_pkg::FMT_NONE && fe_nxt == ktxhp_pkg::ST_OK)
                fe_nxt = ktxhp_pkg::ST_FORMAT;
            end
            ktxhp_pkg::HW_WIDTH:  w_nxt = ws_sh;
            ktxhp_pkg::HW_HEIGHT: h_nxt = ws_sh;
            ktxhp_pkg::HW_DEPTH, ktxhp_pkg::HW_ARRAY:
              if (ws_sh != 32'd0 && fe_nxt == ktxhp_pkg::ST_OK)
                fe_nxt = ktxhp_pkg::ST_SHAPE;
            ktxhp_pkg::HW_FACES:
              if (ws_sh != 32'd1 && fe_nxt == ktxhp_pkg::ST_OK)
                fe_nxt = ktxhp_pkg::ST_SHAPE;
            ktxhp_pkg::HW_MIPS:
              if (ws_sh > 32'd1 && fe_nxt == ktxhp_pkg::ST_OK)
                fe_nxt = ktxhp_pkg::ST_SHAPE;
            ktxhp_pkg::HW_KVLEN: begin
              ps_nxt   = ktxhp_pkg::HDR_LEN + {2'b00, ws_sh};
              ps4_nxt  = ktxhp_pkg::MIN_LEN + {2'b00, ws_sh};
              pend_nxt = {1'b0, ktxhp_pkg::MIN_LEN + {2'b00, ws_sh}};
            end
            default: ;
          endcase
        end
      end else if (p_r >= ps_r && p_r < ps4_r) begin
        ws_nxt = ws_sh;
        if (p_inc == ps4_r) begin
          isw_nxt  = ws_sh;
          pend_nxt = {1'b0, ps4_r} + {3'b000, ws_sh};
        end
      end else if (p_r >= ps4_r && {1'b0, p_r} < pend_r) begin
        pay_v = (fe_r == ktxhp_pkg::ST_OK);
      end
      p_nxt = p_inc;
    end

    len = p_nxt;
    if (len < ktxhp_pkg::MIN_LEN)                      st = ktxhp_pkg::ST_BAD_HEADER;
    else if (fe_nxt != ktxhp_pkg::ST_OK)               st = fe_nxt;
    else if (len < ps4_nxt)                            st = ktxhp_pkg::ST_SIZE_WORD;
    else if ({1'b0, len} < pend_nxt)                   st = ktxhp_pkg::ST_PAYLOAD;
    else if (!ktxhp_pkg::dims_ok(w_nxt, h_nxt))        st = ktxhp_pkg::ST_DIMS;
    else if ({32'd0, isw_nxt} != exp_size)             st = ktxhp_pkg::ST_MISMATCH;
    else                                               st = ktxhp_pkg::ST_OK;

    pay.kind = ktxhp_pkg::KIND_PAYLOAD;
    pay.pb   = file_byte;
    pay.st   = ktxhp_pkg::ST_OK;
    pay.pf   = fmt_r;
    pay.w    = w_r;
    pay.h    = h_r;
    pay.last = !end_of_file;

    sts.kind = ktxhp_pkg::KIND_STATUS;
    sts.pb   = 8'd0;
    sts.st   = st;
    sts.pf   = (st == ktxhp_pkg::ST_OK) ? fmt_nxt : ktxhp_pkg::FMT_ETC1;
    sts.w    = (st == ktxhp_pkg::ST_OK) ? w_nxt : 32'd0;
    sts.h    = (st == ktxhp_pkg::ST_OK) ? h_nxt : 32'd0;
    sts.last = 1'b1;

    push.e0 = pay_v ? pay : sts;
    push.e1 = sts;
    push.n  = 2'd0;
    if (acc)
      push.n = {1'b0, pay_v} + {1'b0, end_of_file};

    // end of file: back to the reset state for the next file
    if (end_of_file) begin
      p_nxt    = '0;
      ws_nxt   = '0;
      fe_nxt   = ktxhp_pkg::ST_OK;
      t0_nxt   = '0;
      t1_nxt   = '0;
      fmt_nxt  = ktxhp_pkg::FMT_NONE;
      w_nxt    = '0;
      h_nxt    = '0;
      ps_nxt   = ktxhp_pkg::HDR_LEN;
      ps4_nxt  = ktxhp_pkg::MIN_LEN;
      isw_nxt  = '0;
      pend_nxt = {1'b0, ktxhp_pkg::MIN_LEN};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r    <= '0;
      ws_r   <= '0;
      fe_r   <= ktxhp_pkg::ST_OK;
      t0_r   <= '0;
      t1_r   <= '0;
      fmt_r  <= ktxhp_pkg::FMT_NONE;
      w_r    <= '0;
      h_r    <= '0;
      ps_r   <= ktxhp_pkg::HDR_LEN;
      ps4_r  <= ktxhp_pkg::MIN_LEN;
      isw_r  <= '0;
      pend_r <= {1'b0, ktxhp_pkg::MIN_LEN};
    end else if (acc) begin
      p_r    <= p_nxt;
      ws_r   <= ws_nxt;
      fe_r   <= fe_nxt;
      t0_r   <= t0_nxt;
      t1_r   <= t1_nxt;
      fmt_r  <= fmt_nxt;
      w_r    <= w_nxt;
      h_r    <= h_nxt;
      ps_r   <= ps_nxt;
      ps4_r  <= ps4_nxt;
      isw_r  <= isw_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign width  = w_r;
  assign height = h_r;
  assign fmt    = fmt_r;

endmodule

// ===== hdl/ktxhp_fifo.sv =====
// four-entry result queue, takes up to two results per cycle, gives one
// depends on ktxhp_pkg
module ktxhp_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ktxhp_pkg::push_t             push,
  input  logic                         pop,
  output ktxhp_pkg::result_t           head,
  output logic [ktxhp_pkg::QCNT_W-1:0] cnt
);

  ktxhp_pkg::result_t                  mem_r [ktxhp_pkg::QDEPTH];
  logic [ktxhp_pkg::QIDX_W-1:0]        wp_r, wp_nxt, rp_r, rp_nxt, wp_1;
  logic [ktxhp_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;

  assign wp_1    = wp_r + 2'd1;
  assign wp_nxt  = wp_r + push.n;
  assign rp_nxt  = rp_r + {1'b0, pop};
  assign cnt_nxt = cnt_r + {1'b0, push.n} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (push.n != 2'd0)
      mem_r[wp_r] <= push.e0;
    if (push.n == 2'd2)
      mem_r[wp_1] <= push.e1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign head = mem_r[rp_r];
  assign cnt  = cnt_r;

endmodule

// ===== hdl/ktx1_texture_header_parser_unit.sv =====
// ktx 1.1 texture header parser: walks a container one word (byte) per cycle while
// in_tready is high, which needs room in the result queue for two results
// a final word with payload gives two results
// rate is set by the four-entry result queue, which pops one result per out_tready cycle
// reset: rst_n synchronous active low; clears parser state and the queue
// depends on ktxhp_pkg, ktxhp_parse, ktxhp_size, ktxhp_fifo
module ktx1_texture_header_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] file_byte
  input  logic        in_tlast,   // end_of_file
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] payload_byte, [11:8] status_code, [13:12] pixel_format,
  // [45:14] image_width, [77:46] image_height, [79:78] zero
  output logic [79:0] out_tdata,
  output logic        out_tuser,  // result_kind
  output logic        out_tlast   // run_last
);

  logic                          in_acc;
  logic                          out_acc;
  logic [31:0]                   hdr_w;
  logic [31:0]                   hdr_h;
  ktxhp_pkg::fmt_t               hdr_fmt;
  logic [63:0]                   exp_size;
  ktxhp_pkg::push_t              push;
  ktxhp_pkg::result_t            head;
  logic [ktxhp_pkg::QCNT_W-1:0]  q_cnt;

  // a word is taken only while the queue has room for two results
  assign in_tready = (q_cnt < 3'(ktxhp_pkg::QDEPTH - 1));
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (q_cnt != '0);
  assign out_acc    = out_tvalid && out_tready;

  // header walk, payload window and status
  ktxhp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_acc),
    .file_byte   (in_tdata),
    .end_of_file (in_tlast),
    .exp_size    (exp_size),
    .width       (hdr_w),
    .height      (hdr_h),
    .fmt         (hdr_fmt),
    .push        (push)
  );

  // size product is registered in prod_r and then scaled into exp_r, long before a status
  ktxhp_size u_size (
    .clk      (clk),
    .width    (hdr_w),
    .height   (hdr_h),
    .fmt      (hdr_fmt),
    .exp_size (exp_size)
  );

  // result queue decouples the two sides
  ktxhp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_acc),
    .head  (head),
    .cnt   (q_cnt)
  );

  assign out_tdata = {2'b00, head.h, head.w, head.pf, head.st, head.pb};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= 3'(ktxhp_pkg::QDEPTH))
    else $error("result queue overflow");

  // two results only for an accepted final word
  a_two_eof: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> in_acc && in_tlast)
    else $error("double push without end of file");

  // status results close the run
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("status result not marked last");

  // failed status carries no image info
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && head.st != ktxhp_pkg::ST_OK |->
      head.w == 32'd0 && head.h == 32'd0)
    else $error("failed status with image info");

endmodule

// ===== tb/ktxhp_checker.sv =====
// result checker for the ktx 1.1 texture header parser: predicts every result word
// from the accepted input words and compares it with the result channel
// depends on ktxhp_pkg for status, format and kind codes and the header constants
module ktxhp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          results_due
);

  typedef struct {
    ktxhp_pkg::kind_t   kind;
    logic [7:0]         pbyte;
    ktxhp_pkg::status_t status;
    ktxhp_pkg::fmt_t    fmt;
    logic [31:0]        width;
    logic [31:0]        height;
    logic               last;
  } ktx_result_t;

  // identifier bytes, first byte lowest
  localparam logic [95:0] KTX_MAGIC = 96'h0a1a0a0d_bb313120_58544bab;

  logic [63:0]        file_pos;
  logic [31:0]        word_acc;
  ktxhp_pkg::status_t first_err;
  logic [31:0]        type_w, fmt_w, ifmt_w;
  logic [31:0]        width_w, height_w;
  logic [63:0]        size_word_at;
  logic [31:0]        image_size;
  logic [63:0]        payload_size_exp;
  ktx_result_t        parser_results_due[$];

  initial fail_count = 0;

  function automatic ktxhp_pkg::fmt_t current_format();
    if (type_w == 32'd0 && fmt_w == 32'd0 && ifmt_w == ktxhp_pkg::GL_ETC1)
      return ktxhp_pkg::FMT_ETC1;
    if (type_w == ktxhp_pkg::GL_US565 && fmt_w == ktxhp_pkg::GL_RGB &&
        ifmt_w == ktxhp_pkg::IFMT_RGB565)
      return ktxhp_pkg::FMT_RGB565;
    if (type_w == ktxhp_pkg::GL_UBYTE && fmt_w == ktxhp_pkg::GL_RGBA &&
        ifmt_w == ktxhp_pkg::IFMT_RGBA8)
      return ktxhp_pkg::FMT_RGBA8888;
    return ktxhp_pkg::FMT_NONE;
  endfunction

  function automatic logic dims_valid();
    return ($signed(width_w) > 0) && ($signed(height_w) > 0);
  endfunction

  task automatic flag_error(input ktxhp_pkg::status_t code);
    if (first_err == ktxhp_pkg::ST_OK) first_err = code;
  endtask

  task automatic clear_parser();
    file_pos         = 64'd0;
    word_acc         = 32'd0;
    first_err        = ktxhp_pkg::ST_OK;
    type_w           = 32'd0;
    fmt_w            = 32'd0;
    ifmt_w           = 32'd0;
    width_w          = 32'd0;
    height_w         = 32'd0;
    size_word_at     = 64'(ktxhp_pkg::HDR_LEN);
    image_size       = 32'd0;
    payload_size_exp = 64'd0;
  endtask

  task automatic take_header_word(input logic [3:0] idx, input logic [31:0] w);
    case (idx)
      ktxhp_pkg::HW_ENDIAN:
        if (w != ktxhp_pkg::ENDIAN_MARK) flag_error(ktxhp_pkg::ST_ENDIAN);
      ktxhp_pkg::HW_TYPE:    type_w = w;
      ktxhp_pkg::HW_FORMAT:  fmt_w = w;
      ktxhp_pkg::HW_IFORMAT: begin
        ifmt_w = w;
        if (current_format() == ktxhp_pkg::FMT_NONE) flag_error(ktxhp_pkg::ST_FORMAT);
      end
      ktxhp_pkg::HW_WIDTH:   width_w = w;
      ktxhp_pkg::HW_HEIGHT: begin
        height_w = w;
        if (dims_valid()) begin
          case (current_format())
            ktxhp_pkg::FMT_ETC1:
              payload_size_exp = ((64'(width_w) + 64'd3) >> 2) *
                                 ((64'(height_w) + 64'd3) >> 2) * 64'd8;
            ktxhp_pkg::FMT_RGB565:
              payload_size_exp = 64'(width_w) * 64'(height_w) * 64'd2;
            ktxhp_pkg::FMT_RGBA8888:
              payload_size_exp = 64'(width_w) * 64'(height_w) * 64'd4;
            default: ;
          endcase
        end
      end
      ktxhp_pkg::HW_DEPTH, ktxhp_pkg::HW_ARRAY:
        if (w != 32'd0) flag_error(ktxhp_pkg::ST_SHAPE);
      ktxhp_pkg::HW_FACES:   if (w != 32'd1) flag_error(ktxhp_pkg::ST_SHAPE);
      ktxhp_pkg::HW_MIPS:    if (w > 32'd1) flag_error(ktxhp_pkg::ST_SHAPE);
      ktxhp_pkg::HW_KVLEN:   size_word_at = 64'(ktxhp_pkg::HDR_LEN) + 64'(w);
      default: ;
    endcase
  endtask

  task automatic parse_file_byte(input logic [7:0] b, input logic eof);
    logic [63:0]        p;
    logic [63:0]        body;
    ktxhp_pkg::status_t st;
    ktx_result_t        r;
    p    = file_pos;
    body = size_word_at + 64'd4;
    if (p != 64'(ktxhp_pkg::POS_MAX)) begin
      if (p < 64'(ktxhp_pkg::IDENT_LEN)) begin
        if (b != KTX_MAGIC[{p[3:0], 3'b000} +: 8]) flag_error(ktxhp_pkg::ST_BAD_HEADER);
      end
      if (p < 64'(ktxhp_pkg::HDR_LEN)) begin
        word_acc = {b, word_acc[31:8]};
        if (p[1:0] == 2'd3) take_header_word(p[5:2], word_acc);
      end else if (p >= size_word_at && p < body) begin
        word_acc = {b, word_acc[31:8]};
        if (p == body - 64'd1) image_size = word_acc;
      end else if (p >= body && (p - body) < 64'(image_size)) begin
        // payload only while the file is still clean
        if (first_err == ktxhp_pkg::ST_OK) begin
          r = '{ktxhp_pkg::KIND_PAYLOAD, b, ktxhp_pkg::ST_OK, current_format(), width_w,
                height_w, !eof};
          parser_results_due.insert(parser_results_due.size(), r);
        end
      end
      file_pos = p + 64'd1;
    end
    if (eof) begin
      body = size_word_at + 64'd4;
      if (file_pos < 64'(ktxhp_pkg::MIN_LEN))       st = ktxhp_pkg::ST_BAD_HEADER;
      else if (first_err != ktxhp_pkg::ST_OK)       st = first_err;
      else if (file_pos < body)                     st = ktxhp_pkg::ST_SIZE_WORD;
      else if (file_pos - body < 64'(image_size))   st = ktxhp_pkg::ST_PAYLOAD;
      else if (!dims_valid())                       st = ktxhp_pkg::ST_DIMS;
      else if (64'(image_size) != payload_size_exp) st = ktxhp_pkg::ST_MISMATCH;
      else                                          st = ktxhp_pkg::ST_OK;
      if (st == ktxhp_pkg::ST_OK)
        r = '{ktxhp_pkg::KIND_STATUS, 8'd0, ktxhp_pkg::ST_OK, current_format(), width_w,
              height_w, 1'b1};
      else
        r = '{ktxhp_pkg::KIND_STATUS, 8'd0, st, ktxhp_pkg::FMT_ETC1, 32'd0, 32'd0, 1'b1};
      parser_results_due.insert(parser_results_due.size(), r);
      clear_parser();
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
    if (seen !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, seen);
      fail_count++;
    end
  endtask

  task automatic check_result();
    ktx_result_t e;
    if (parser_results_due.size() == 0) begin
      $error("result word with none expected: kind %0d status %0d", out_tuser,
             out_tdata[11:8]);
      fail_count++;
    end else begin
      e = parser_results_due.pop_front();
      compare_field("result_kind", e.kind, out_tuser);
      compare_field("payload_byte", e.pbyte, out_tdata[7:0]);
      compare_field("status_code", e.status, out_tdata[11:8]);
      compare_field("pixel_format", e.fmt, out_tdata[13:12]);
      compare_field("image_width", e.width, out_tdata[45:14]);
      compare_field("image_height", e.height, out_tdata[77:46]);
      compare_field("run_last", e.last, out_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      parser_results_due.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) parse_file_byte(in_tdata, in_tlast);
    end
    results_due = parser_results_due.size();
  end

endmodule

// ===== tb/tb.sv =====
// top of the ktx 1.1 header parser bench: builds container files, streams them into
// the parser with random gaps and result stalls, and gives the verdict
// depends on ktxhp_pkg, ktx1_texture_header_parser_unit and ktxhp_checker
module tb;

  localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int HOLD_START  = 600;   // receiver cycle where the long hold-off begins
  localparam int HOLD_CYCLES = 300;

  // fields of one container file, header words in file order
  typedef struct {
    logic [31:0] type_w, fmt_w, ifmt_w;
    logic [31:0] width, height, depth, layers, faces, mips;
    logic [31:0] kv_len, image_size;
    int unsigned payload_len;
  } ktx_layout_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int fail_count;
  int results_due;
  int bytes_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  logic [7:0] file_bytes[$];  // the file being built, in stream order

  always #10 clk = ~clk;

  ktx1_texture_header_parser_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  ktxhp_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // well-formed layout for one format, size word matching the payload
  function automatic ktx_layout_t valid_layout(input ktxhp_pkg::fmt_t f, input int unsigned w,
                                               input int unsigned h);
    ktx_layout_t l;
    l.width  = w;
    l.height = h;
    l.depth  = 32'd0;
    l.layers = 32'd0;
    l.faces  = 32'd1;
    l.mips   = $urandom_range(0, 1);
    l.kv_len = 32'd0;
    case (f)
      ktxhp_pkg::FMT_RGB565: begin
        l.type_w = ktxhp_pkg::GL_US565; l.fmt_w = ktxhp_pkg::GL_RGB;
        l.ifmt_w = ktxhp_pkg::IFMT_RGB565;
        l.image_size = w * h * 2;
      end
      ktxhp_pkg::FMT_RGBA8888: begin
        l.type_w = ktxhp_pkg::GL_UBYTE; l.fmt_w = ktxhp_pkg::GL_RGBA;
        l.ifmt_w = ktxhp_pkg::IFMT_RGBA8;
        l.image_size = w * h * 4;
      end
      default: begin
        l.type_w = 32'd0; l.fmt_w = 32'd0; l.ifmt_w = ktxhp_pkg::GL_ETC1;
        l.image_size = ((w + 3) / 4) * ((h + 3) / 4) * 8;
      end
    endcase
    l.payload_len = l.image_size;
    return l;
  endfunction

  // one byte onto the end of the file
  function automatic void add_byte(input logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endfunction

  // little-endian word into the file
  function automatic void put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) add_byte(w[8*i +: 8]);
  endfunction

  function automatic void build_file(input ktx_layout_t l);
    int unsigned kv_bytes;
    file_bytes.delete();
    for (int i = 0; i < 12; i++) add_byte(ktxhp_pkg::ident_byte(4'(i)));
    put_word(ktxhp_pkg::ENDIAN_MARK);
    put_word(l.type_w);
    put_word(32'd1);          // type size, not checked
    put_word(l.fmt_w);
    put_word(l.ifmt_w);
    put_word(l.fmt_w);        // base internal format, not checked
    put_word(l.width);
    put_word(l.height);
    put_word(l.depth);
    put_word(l.layers);
    put_word(l.faces);
    put_word(l.mips);
    put_word(l.kv_len);
    // a huge key-value length only gets a short tail, the file ends inside it
    kv_bytes = (l.kv_len > 32'd64) ? 16 : l.kv_len;
    for (int i = 0; i < kv_bytes; i++) add_byte(8'($urandom));
    put_word(l.image_size);
    for (int i = 0; i < l.payload_len; i++) add_byte(8'($urandom));
  endfunction

  // one input word; gaps come between bursts of random length
  task automatic send_word(input logic [7:0] value, input logic eof);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= eof;
    // ready is settled by the falling edge; the word moves at the next rising edge
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      send_word(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  task automatic send_layout(input ktx_layout_t l);
    build_file(l);
    send_file();
  endtask

  // receiver: random stall modes plus one long hold-off so the result queue fills up
  initial begin
    int rx_cycle;
    int mode;
    rx_cycle = 0;
    mode     = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 64 == 0) mode = $urandom_range(0, 3);
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
        out_tready <= 1'b0;
      else begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= $urandom_range(0, 1);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // watchdog: ends the run when no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    ktx_layout_t l;
    int          stop_at;
    int          pick;
    int          n;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // clean files of each format, etc1 with rounding, key-value bytes, no mip level
    send_layout(valid_layout(ktxhp_pkg::FMT_ETC1, 1, 1));
    send_layout(valid_layout(ktxhp_pkg::FMT_ETC1, 5, 7));
    send_layout(valid_layout(ktxhp_pkg::FMT_RGB565, 3, 2));
    l = valid_layout(ktxhp_pkg::FMT_RGBA8888, 2, 1);
    l.kv_len = 32'd5;
    l.mips   = 32'd0;
    send_layout(l);

    // one-word file and a file one word short of the minimum length
    file_bytes = '{8'hab};
    send_file();
    build_file(valid_layout(ktxhp_pkg::FMT_ETC1, 1, 1));
    while (file_bytes.size() > 67) void'(file_bytes.pop_back());
    send_file();

    // broken identifier, wrong endianness marker
    build_file(valid_layout(ktxhp_pkg::FMT_RGB565, 1, 1));
    file_bytes[11] = 8'hff;
    send_file();
    build_file(valid_layout(ktxhp_pkg::FMT_RGB565, 1, 1));
    file_bytes[12] = 8'h04;
    send_file();

    // unsupported format: payload bytes present but never passed on
    l = valid_layout(ktxhp_pkg::FMT_ETC1, 2, 2);
    l.ifmt_w = ktxhp_pkg::IFMT_RGBA8;
    send_layout(l);

    // shape words: depth, array count, faces, mip levels
    l = valid_layout(ktxhp_pkg::FMT_ETC1, 1, 1);
    l.depth = 32'd1;
    send_layout(l);
    l = valid_layout(ktxhp_pkg::FMT_ETC1, 1, 1);
    l.layers = 32'hffff_ffff;
    send_layout(l);
    l = valid_layout(ktxhp_pkg::FMT_ETC1, 1, 1);
    l.faces = 32'd6;
    send_layout(l);
    l = valid_layout(ktxhp_pkg::FMT_ETC1, 1, 1);
    l.mips = 32'd2;
    send_layout(l);

    // huge key-value length so the size word never completes, then a cut inside the payload
    l = valid_layout(ktxhp_pkg::FMT_RGBA8888, 1, 1);
    l.kv_len = 32'hffff_fff0;
    send_layout(l);
    build_file(valid_layout(ktxhp_pkg::FMT_RGBA8888, 1, 1));
    while (file_bytes.size() > 70) void'(file_bytes.pop_back());
    send_file();

    // payload cut short, and an all-ones size word
    build_file(valid_layout(ktxhp_pkg::FMT_ETC1, 4, 4));
    void'(file_bytes.pop_back());
    send_file();
    l = valid_layout(ktxhp_pkg::FMT_RGB565, 1, 1);
    l.image_size  = 32'hffff_ffff;
    l.payload_len = 3;
    send_layout(l);

    // dimensions not positive, exactly the minimum length
    l = valid_layout(ktxhp_pkg::FMT_ETC1, 1, 1);
    l.width = 32'd0; l.image_size = 32'd0; l.payload_len = 0;
    send_layout(l);
    l = valid_layout(ktxhp_pkg::FMT_ETC1, 1, 1);
    l.width = 32'h8000_0000; l.height = 32'hffff_ffff;
    l.image_size = 32'd0; l.payload_len = 0;
    send_layout(l);

    // size mismatch: largest dimensions, then one byte off
    l = valid_layout(ktxhp_pkg::FMT_RGBA8888, 1, 1);
    l.width = 32'h7fff_ffff; l.height = 32'h7fff_ffff;
    l.image_size = 32'd0; l.payload_len = 0;
    send_layout(l);
    l = valid_layout(ktxhp_pkg::FMT_RGB565, 2, 2);
    l.image_size = 32'd7; l.payload_len = 7;
    send_layout(l);

    // trailing words after the payload are ignored
    build_file(valid_layout(ktxhp_pkg::FMT_RGB565, 2, 1));
    repeat (3) add_byte(8'($urandom));
    send_file();

    // random part: mostly well-formed files with random content, the rest broken or noise
    stop_at = bytes_sent + 200;
    while (bytes_sent < stop_at) begin
      l = valid_layout(ktxhp_pkg::fmt_t'($urandom_range(0, 2)), $urandom_range(1, 6),
                       $urandom_range(1, 6));
      if ($urandom_range(0, 3) == 0) l.kv_len = $urandom_range(1, 12);
      pick = $urandom_range(0, 99);
      if (pick >= 55 && pick < 65) begin
        case ($urandom_range(0, 5))
          0: l.image_size = l.image_size + 1;
          1: l.image_size = l.image_size - 1;
          2: begin
            l.width = $urandom; l.height = $urandom;
            l.image_size = 32'd0; l.payload_len = 0;
          end
          3: l.faces = $urandom_range(0, 2);
          4: l.mips = $urandom_range(0, 3);
          default: l.type_w = $urandom;
        endcase
      end
      build_file(l);
      if (pick >= 65 && pick < 75) begin
        file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
      end else if (pick >= 75 && pick < 85) begin
        n = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > n) void'(file_bytes.pop_back());
      end else if (pick >= 85 && pick < 90) begin
        repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
      end else if (pick >= 90) begin
        // noise, sometimes behind a correct identifier
        file_bytes.delete();
        n = $urandom_range(1, 90);
        for (int i = 0; i < n; i++)
          add_byte((i < 12 && pick[0]) ? ktxhp_pkg::ident_byte(4'(i)) : 8'($urandom));
      end
      send_file();
    end
    in_tvalid <= 1'b0;

    // drain: every predicted result must come out
    do @(negedge clk); while (results_due != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
